@@ sv/csi_pkg.sv @@
// csi_pkg: shared types, constants and helpers for the ANSI CSI console parser.
// Used by csi_step, csi_emit and ansi_csi_console_parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csi_pkg;

   // Geometry and parser sizing
   localparam int CSI_NUM_PARAMS  = 3;
   localparam int CSI_SCREEN_COLS = 80;
   localparam int CSI_IDX_W       = $clog2(CSI_NUM_PARAMS);
   localparam int CSI_PARAM_W     = 16;
   localparam int CSI_MAX_RSP     = 5;
   localparam int CSI_CNT_W       = $clog2(CSI_MAX_RSP + 1);
   localparam int CSI_POS_W       = $clog2(CSI_MAX_RSP);

   // Linear cursor position and its reciprocal division by the screen width
   localparam int CSI_LIN_W     = 16;
   localparam int CSI_DIV_SHIFT = CSI_LIN_W + 8;
   localparam int CSI_DIV_RECIP = ((2 ** CSI_DIV_SHIFT) + CSI_SCREEN_COLS - 1) / CSI_SCREEN_COLS;
   localparam int CSI_PROD_W    = CSI_DIV_SHIFT + CSI_LIN_W;

   // Character codes
   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_ESC    = 8'h1B;
   localparam logic [7:0] CHR_LBRACK = 8'h5B;
   localparam logic [7:0] CHR_SEMI   = 8'h3B;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_AT     = 8'h40;
   localparam logic [7:0] CHR_UP     = 8'h41;
   localparam logic [7:0] CHR_FWD    = 8'h43;
   localparam logic [7:0] CHR_BACK   = 8'h44;
   localparam logic [7:0] CHR_POS    = 8'h48;
   localparam logic [7:0] CHR_SGR    = 8'h6D;

   // SGR codes and colours
   localparam logic [CSI_PARAM_W-1:0] SGR_FG_EXT  = 16'd38;
   localparam logic [CSI_PARAM_W-1:0] SGR_BG_EXT  = 16'd48;
   localparam logic [CSI_PARAM_W-1:0] SGR_PALETTE = 16'd5;
   localparam logic [7:0]             FG_DEFAULT  = 8'd7;
   localparam logic [7:0]             BG_DEFAULT  = 8'd0;
   localparam logic [CSI_PARAM_W-1:0] PARAM_MAX   = 16'hFFFF;

   typedef enum logic [2:0] {
      KIND_SERIAL   = 3'd0,
      KIND_TELETYPE = 3'd1,
      KIND_WRITE    = 3'd2,
      KIND_CURSOR   = 3'd3,
      KIND_BG       = 3'd4
   } csi_kind_type;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'b001,
      MODE_ESCAPE = 3'b010,
      MODE_CSI    = 3'b100
   } csi_mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic [7:0] cursor_row;
      logic [7:0] cursor_col;
   } csi_req_type;

   typedef struct packed {
      csi_kind_type kind;
      logic [7:0]   char_code;
      logic [7:0]   new_row;
      logic [7:0]   new_col;
      logic [7:0]   color;
      logic [7:0]   fg_color;
      logic         last;
   } csi_rsp_type;

   typedef struct packed {
      csi_mode_type                              mode;
      logic [CSI_IDX_W-1:0]                      index;
      logic [CSI_NUM_PARAMS-1:0][CSI_PARAM_W-1:0] values;
      logic [7:0]                                foreground;
   } csi_state_type;

   // Results caused by one byte, slot 0 first
   typedef struct packed {
      logic [CSI_CNT_W-1:0]               count;
      csi_rsp_type [CSI_MAX_RSP-1:0]      slot;
   } csi_bundle_type;

   // Build one result with foreground and last flag still clear
   function automatic csi_rsp_type csi_make(input csi_kind_type kind, input logic [7:0] ch,
                                             input logic [7:0] row, input logic [7:0] col,
                                             input logic [7:0] color);
      csi_rsp_type r;
      r.kind      = kind;
      r.char_code = ch;
      r.new_row   = row;
      r.new_col   = col;
      r.color     = color;
      r.fg_color  = 8'd0;
      r.last      = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/csi_step.sv @@
// csi_step: combinational step of the parser for one registered byte.
// Produces the result bundle and the next parser state. Depends on csi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csi_step import csi_pkg::*; (
   input  csi_req_type    req,
   input  csi_state_type  state,
   output csi_state_type  state_next,
   output csi_bundle_type bundle
);

   logic [CSI_PARAM_W-1:0] raw0;
   logic [CSI_PARAM_W-1:0] p1;
   logic [CSI_PARAM_W-1:0] p2;
   logic [CSI_PARAM_W-1:0] p3;
   logic [CSI_PARAM_W-1:0] p2_pos;
   logic [CSI_PARAM_W-1:0] cur_val;
   logic [CSI_PARAM_W+3:0] acc;
   logic [CSI_LIN_W-1:0]   base;
   logic [CSI_LIN_W-1:0]   lin;
   logic [CSI_PROD_W-1:0]  prod;
   logic [CSI_LIN_W-1:0]   quot;
   logic [CSI_LIN_W-1:0]   rem;
   logic [7:0]             up_row;
   logic [CSI_POS_W-1:0]   n;
   logic                   is_digit;
   csi_rsp_type [CSI_MAX_RSP-1:0] slots;

   // Pick out the parameters; those beyond the array read as zero
   always_comb begin
      raw0 = '0;
      p2   = '0;
      p3   = '0;
      for (int i = 0; i < CSI_NUM_PARAMS; i++) begin
         if (i == 0) raw0 = state.values[i];
         if (i == 1) p2 = state.values[i];
         if (i == 2) p3 = state.values[i];
      end
      p1      = (raw0 == '0) ? CSI_PARAM_W'(1) : raw0;
      p2_pos  = (p2 == '0) ? CSI_PARAM_W'(1) : p2;
      cur_val = state.values[state.index];
   end

   // Decimal accumulate with saturation
   assign is_digit = (req.in_byte >= CHR_ZERO) && (req.in_byte <= CHR_NINE);
   assign acc      = ({4'd0, cur_val} << 3) + ({4'd0, cur_val} << 1)
                   + {12'd0, req.in_byte - CHR_ZERO};

   // Cursor up clamps at row zero
   assign up_row = ({8'd0, req.cursor_row} >= p1) ? 8'(16'(req.cursor_row) - p1) : 8'd0;

   // Cursor back: linear position, clamp, then divide by the width via reciprocal
   assign base = CSI_LIN_W'(16'(req.cursor_row) * 16'(CSI_SCREEN_COLS)) + 16'(req.cursor_col);
   assign lin  = (base >= p1) ? base - p1 : '0;
   assign prod = CSI_PROD_W'(lin) * CSI_PROD_W'(CSI_DIV_RECIP);
   assign quot = prod[CSI_DIV_SHIFT +: CSI_LIN_W];
   assign rem  = lin - CSI_LIN_W'(quot * CSI_LIN_W'(CSI_SCREEN_COLS));

   // Sequence the results and advance the parser
   always_comb begin
      slots      = '0;
      n          = '0;
      state_next = state;

      if (req.in_byte == CHR_NL) begin
         slots[n] = csi_make(KIND_SERIAL, CHR_CR, 8'd0, 8'd0, 8'd0);
         n        = n + 1'b1;
         slots[n] = csi_make(KIND_TELETYPE, CHR_CR, 8'd0, 8'd0, 8'd0);
         n        = n + 1'b1;
      end
      slots[n] = csi_make(KIND_SERIAL, req.in_byte, 8'd0, 8'd0, 8'd0);
      n        = n + 1'b1;

      case (state.mode)
         MODE_CSI: begin
            if (req.in_byte == CHR_SEMI) begin
               if (state.index < CSI_IDX_W'(CSI_NUM_PARAMS - 1))
                  state_next.index = state.index + 1'b1;
            end else if (is_digit) begin
               state_next.values[state.index] = (acc > {4'd0, PARAM_MAX}) ? PARAM_MAX
                                                : acc[CSI_PARAM_W-1:0];
            end else begin
               state_next.mode = MODE_NORMAL;
               // Final byte: issue the display command it names, if any
               if (req.in_byte == CHR_AT) begin
                  slots[n] = csi_make(KIND_WRITE, p1[7:0], 8'd0, 8'd0, state.foreground);
                  n        = n + 1'b1;
               end else if (req.in_byte == CHR_UP) begin
                  slots[n] = csi_make(KIND_CURSOR, 8'd0, up_row, req.cursor_col, 8'd0);
                  n        = n + 1'b1;
               end else if (req.in_byte == CHR_FWD) begin
                  slots[n] = csi_make(KIND_CURSOR, 8'd0, req.cursor_row,
                                      8'(16'(req.cursor_col) + p1), 8'd0);
                  n        = n + 1'b1;
               end else if (req.in_byte == CHR_BACK) begin
                  slots[n] = csi_make(KIND_CURSOR, 8'd0, quot[7:0], rem[7:0], 8'd0);
                  n        = n + 1'b1;
               end else if (req.in_byte == CHR_POS) begin
                  slots[n] = csi_make(KIND_CURSOR, 8'd0, 8'(p1 - 1'b1), 8'(p2_pos - 1'b1),
                                      8'd0);
                  n        = n + 1'b1;
               end else if (req.in_byte == CHR_SGR) begin
                  if (raw0 == '0) begin
                     state_next.foreground = FG_DEFAULT;
                     slots[n] = csi_make(KIND_BG, 8'd0, 8'd0, 8'd0, BG_DEFAULT);
                     n        = n + 1'b1;
                  end else if (raw0 == SGR_FG_EXT) begin
                     if (p2 == SGR_PALETTE)
                        state_next.foreground = p3[7:0];
                  end else if (raw0 == SGR_BG_EXT) begin
                     if (p2 == SGR_PALETTE) begin
                        slots[n] = csi_make(KIND_BG, 8'd0, 8'd0, 8'd0, p3[7:0]);
                        n        = n + 1'b1;
                     end
                  end
               end
            end
         end
         MODE_ESCAPE: begin
            if (req.in_byte == CHR_LBRACK) begin
               state_next.mode   = MODE_CSI;
               state_next.values = '0;
               state_next.index  = '0;
            end else begin
               slots[n] = csi_make(KIND_TELETYPE, CHR_ESC, 8'd0, 8'd0, 8'd0);
               n        = n + 1'b1;
               slots[n] = csi_make(KIND_TELETYPE, req.in_byte, 8'd0, 8'd0, 8'd0);
               n        = n + 1'b1;
               state_next.mode = MODE_NORMAL;
            end
         end
         default: begin
            if (req.in_byte == CHR_ESC) begin
               state_next.mode = MODE_ESCAPE;
            end else begin
               slots[n] = csi_make(KIND_TELETYPE, req.in_byte, 8'd0, 8'd0, 8'd0);
               n        = n + 1'b1;
            end
         end
      endcase

      // Stamp foreground on every result and mark the final one
      for (int i = 0; i < CSI_MAX_RSP; i++) begin
         slots[i].fg_color = state_next.foreground;
         slots[i].last     = (CSI_POS_W'(i) == CSI_POS_W'(n - 1'b1));
      end
      bundle.slot  = slots;
      bundle.count = CSI_CNT_W'(n);
   end

endmodule

`default_nettype wire

@@ sv/csi_emit.sv @@
// csi_emit: result register that holds one byte's bundle and hands out its results
// one transfer at a time. Depends on csi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csi_emit import csi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           load_valid,
   output logic           load_ready,
   input  csi_bundle_type load_bundle,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output csi_rsp_type    rsp_item
);

   csi_bundle_type       bundle_ff, bundle_in;
   logic                 valid_ff, valid_in;
   logic [CSI_POS_W-1:0] pos_ff, pos_in;
   logic                 final_taken;

   assign rsp_item    = bundle_ff.slot[pos_ff];
   assign rsp_valid   = valid_ff;
   assign final_taken = valid_ff && rsp_ready && rsp_item.last;
   assign load_ready  = !valid_ff || final_taken;

   // Load a fresh bundle, otherwise advance through the held one
   always_comb begin
      bundle_in = bundle_ff;
      valid_in  = valid_ff;
      pos_in    = pos_ff;
      if (load_valid && load_ready) begin
         bundle_in = load_bundle;
         valid_in  = 1'b1;
         pos_in    = '0;
      end else if (final_taken) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_ready) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ansi_csi_console_parser.sv @@
// ansi_csi_console_parser: top level of the ANSI CSI console parser.
// Instantiates csi_step and csi_emit; depends on csi_pkg.
//
//   channel | ports                         | direction | carries
//   req     | req_valid req_ready req_item  | in        | byte, cursor row, cursor column
//   rsp     | rsp_valid rsp_ready rsp_item  | out       | one serial or display action
//
// A byte is registered on its transfer and stepped through the parser once the
// result register can take a bundle; its 1 to 5 results are loaded there together.
// The result port gives one result per cycle while rsp_ready holds high, so that
// port sets the sustained rate. A new byte is taken while results wait.
// Reset puts the parser in normal mode with foreground 7 and empties both registers.
// A stall on rsp holds the current result; req stays ready until the input register fills.
`timescale 1ns / 1ps
`default_nettype none

module ansi_csi_console_parser import csi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  csi_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output csi_rsp_type rsp_item
);

   csi_req_type    in_ff, in_in;
   logic           in_valid_ff, in_valid_in;
   csi_state_type  state_ff, state_in;
   csi_state_type  state_next;
   csi_bundle_type bundle;
   logic           load_ready;
   logic           step_go;

   assign step_go   = in_valid_ff && load_ready;
   assign req_ready = !in_valid_ff || load_ready;

   // Parser step on the registered byte
   csi_step u_step (
      .req        (in_ff),
      .state      (state_ff),
      .state_next (state_next),
      .bundle     (bundle)
   );

   // Result register and serialiser
   csi_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (in_valid_ff),
      .load_ready  (load_ready),
      .load_bundle (bundle),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

   // Hold the input byte until it has been stepped; commit state with the step
   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      state_in    = state_ff;
      if (step_go) begin
         in_valid_in = 1'b0;
         state_in    = state_next;
      end
      if (req_valid && req_ready) begin
         in_in       = req_item;
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      if (reset) begin
         in_valid_ff         <= 1'b0;
         state_ff.mode       <= MODE_NORMAL;
         state_ff.index      <= '0;
         state_ff.values     <= '0;
         state_ff.foreground <= FG_DEFAULT;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking testbench for ansi_csi_console_parser.
// Drives console bytes with cursor positions, predicts every serial and display
// action in order and checks each rsp transfer; depends on csi_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import csi_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_BYTES = 50;
   localparam int QUIET_BYTES  = 40;
   localparam int BURST_BYTES  = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   csi_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   csi_rsp_type rsp_item;

   // Idling control and the long receiver hold-off
   logic quiet_sender = 1'b0;
   logic quiet_receiver = 1'b0;
   logic rsp_hold = 1'b0;
   event hold_trigger;

   // Shadow parser state
   csi_mode_type     shadow_mode;
   int               shadow_index;
   logic [15:0]      shadow_params [CSI_NUM_PARAMS];
   logic [7:0]       shadow_fg;

   csi_rsp_type expected_actions [$];
   int          mismatch_count = 0;
   int          sent_bytes = 0;
   int          cycle_count = 0;

   ansi_csi_console_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ansi_csi_console_parser verification failed");
         $finish;
      end
   end

   function automatic csi_rsp_type make_action(csi_kind_type kind, logic [7:0] ch,
                                               logic [7:0] row, logic [7:0] col,
                                               logic [7:0] color);
      csi_rsp_type a;
      a.kind      = kind;
      a.char_code = ch;
      a.new_row   = row;
      a.new_col   = col;
      a.color     = color;
      a.fg_color  = 8'd0;
      a.last      = 1'b0;
      return a;
   endfunction

   task automatic reset_shadow();
      shadow_mode  = MODE_NORMAL;
      shadow_index = 0;
      foreach (shadow_params[i]) shadow_params[i] = '0;
      shadow_fg    = FG_DEFAULT;
   endtask

   // Work out the actions one console byte causes and queue them
   task automatic predict_actions(input csi_req_type it);
      csi_rsp_type acts [$];
      logic [7:0]  b;
      int          crow, ccol, v, raw0, p1, p2, p3, c, base, lin;
      b    = it.in_byte;
      crow = it.cursor_row;
      ccol = it.cursor_col;
      if (b == CHR_NL) begin
         acts.push_back(make_action(KIND_SERIAL, CHR_CR, 0, 0, 0));
         acts.push_back(make_action(KIND_TELETYPE, CHR_CR, 0, 0, 0));
      end
      acts.push_back(make_action(KIND_SERIAL, b, 0, 0, 0));
      case (shadow_mode)
         MODE_CSI: begin
            if (b == CHR_SEMI) begin
               // drop a separator at the last parameter
               if (shadow_index < CSI_NUM_PARAMS - 1) shadow_index++;
            end else if (b >= CHR_ZERO && b <= CHR_NINE) begin
               v = int'(shadow_params[shadow_index]) * 10 + int'(b) - int'(CHR_ZERO);
               shadow_params[shadow_index] = (v > 65535) ? PARAM_MAX : v[15:0];
            end else begin
               shadow_mode = MODE_NORMAL;
               raw0 = shadow_params[0];
               p1   = (raw0 == 0) ? 1 : raw0;
               p2   = shadow_params[1];
               p3   = shadow_params[2];
               case (b)
                  CHR_AT: acts.push_back(make_action(KIND_WRITE, p1[7:0], 0, 0, shadow_fg));
                  CHR_UP: begin
                     v = (crow >= p1) ? crow - p1 : 0;
                     acts.push_back(make_action(KIND_CURSOR, 0, v[7:0], ccol[7:0], 0));
                  end
                  CHR_FWD: begin
                     v = ccol + p1;
                     acts.push_back(make_action(KIND_CURSOR, 0, crow[7:0], v[7:0], 0));
                  end
                  CHR_BACK: begin
                     base = crow * CSI_SCREEN_COLS + ccol;
                     lin  = (base >= p1) ? base - p1 : 0;
                     v    = lin / CSI_SCREEN_COLS;
                     c    = lin % CSI_SCREEN_COLS;
                     acts.push_back(make_action(KIND_CURSOR, 0, v[7:0], c[7:0], 0));
                  end
                  CHR_POS: begin
                     c = (p2 == 0) ? 1 : p2;
                     v = p1 - 1;
                     c = c - 1;
                     acts.push_back(make_action(KIND_CURSOR, 0, v[7:0], c[7:0], 0));
                  end
                  CHR_SGR: begin
                     if (raw0 == 0) begin
                        shadow_fg = FG_DEFAULT;
                        acts.push_back(make_action(KIND_BG, 0, 0, 0, BG_DEFAULT));
                     end else if (raw0 == int'(SGR_FG_EXT)) begin
                        if (p2 == int'(SGR_PALETTE)) shadow_fg = p3[7:0];
                     end else if (raw0 == int'(SGR_BG_EXT)) begin
                        if (p2 == int'(SGR_PALETTE))
                           acts.push_back(make_action(KIND_BG, 0, 0, 0, p3[7:0]));
                     end
                  end
                  default: ;
               endcase
            end
         end
         MODE_ESCAPE: begin
            if (b == CHR_LBRACK) begin
               shadow_mode  = MODE_CSI;
               shadow_index = 0;
               foreach (shadow_params[i]) shadow_params[i] = '0;
            end else begin
               acts.push_back(make_action(KIND_TELETYPE, CHR_ESC, 0, 0, 0));
               acts.push_back(make_action(KIND_TELETYPE, b, 0, 0, 0));
               shadow_mode = MODE_NORMAL;
            end
         end
         default: begin
            if (b == CHR_ESC) shadow_mode = MODE_ESCAPE;
            else acts.push_back(make_action(KIND_TELETYPE, b, 0, 0, 0));
         end
      endcase
      // stamp the foreground after this step and flag the final action
      foreach (acts[i]) begin
         acts[i].fg_color = shadow_fg;
         acts[i].last     = (i == acts.size() - 1);
         expected_actions.push_back(acts[i]);
      end
   endtask

   // Offer one byte, hold it until the transfer, then maybe idle
   task automatic send_byte(input logic [7:0] b, input logic [7:0] row, input logic [7:0] col);
      csi_req_type it;
      it.in_byte    = b;
      it.cursor_row = row;
      it.cursor_col = col;
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      predict_actions(it);
      sent_bytes++;
      if (!quiet_sender && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_free(input logic [7:0] b);
      send_byte(b, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   // Send ESC [ and then the body, all with one cursor position
   task automatic send_csi(input string body, input logic [7:0] row, input logic [7:0] col);
      send_byte(CHR_ESC, row, col);
      send_byte(CHR_LBRACK, row, col);
      for (int i = 0; i < body.len(); i++) send_byte(body[i], row, col);
   endtask

   task automatic send_number(input int value);
      string digits;
      digits = $sformatf("%0d", value);
      for (int i = 0; i < digits.len(); i++) send_free(digits[i]);
   endtask

   // One random sequence: mostly well-formed CSI, the rest noise and broken ones
   task automatic send_random_sequence();
      int         pick, count, len;
      string      finals;
      logic [7:0] fin;
      bit         colour;
      finals = "@ACDHm";
      pick   = $urandom_range(99);
      if (pick < 60) begin
         send_free(CHR_ESC);
         send_free(CHR_LBRACK);
         colour = ($urandom_range(3) == 0);
         count  = colour ? 0 : $urandom_range(0, 4);
         if (colour) begin
            send_number($urandom_range(1) ? int'(SGR_FG_EXT) : int'(SGR_BG_EXT));
            send_free(CHR_SEMI);
            send_number($urandom_range(4) == 0 ? $urandom_range(9) : int'(SGR_PALETTE));
            send_free(CHR_SEMI);
            send_number($urandom_range(300));
         end
         for (int i = 0; i < count; i++) begin
            if (i > 0) send_free(CHR_SEMI);
            len = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 3);
            repeat (len) send_free(CHR_ZERO + 8'($urandom_range(9)));
         end
         if (colour && $urandom_range(4) != 0) begin
            fin = CHR_SGR;
         end else if ($urandom_range(5) != 0) begin
            fin = finals[$urandom_range(5)];
         end else begin
            do fin = 8'($urandom_range(255));
            while (fin == CHR_SEMI || (fin >= CHR_ZERO && fin <= CHR_NINE));
         end
         send_free(fin);
      end else if (pick < 75) begin
         send_free(8'($urandom_range(255)));
      end else if (pick < 88) begin
         send_free(CHR_ESC);
         send_free(8'($urandom_range(255)));
      end else begin
         send_free(CHR_ESC);
         send_free(CHR_LBRACK);
         repeat ($urandom_range(1, 4)) send_free(8'($urandom_range(255)));
      end
   endtask

   // Receiver: random stalls unless quiet, forced low during a hold-off
   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && (quiet_receiver || $urandom_range(99) >= 11);
   end

   // Hold the receiver off for a counted stretch
   always begin
      @(hold_trigger);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic log_mismatch(input string why, input csi_rsp_type want,
                               input csi_rsp_type got);
      string head;
      mismatch_count++;
      if (mismatch_count <= 10) begin
         head = $sformatf("%s: kind %0d/%0d char %h/%h row %0d/%0d col %0d/%0d",
                          why, want.kind, got.kind, want.char_code, got.char_code,
                          want.new_row, got.new_row, want.new_col, got.new_col);
         $display("%s color %h/%h fg %h/%h last %b/%b (expected/actual)",
                  head, want.color, got.color, want.fg_color, got.fg_color,
                  want.last, got.last);
      end
   endtask

   // Check each rsp transfer against the oldest expected action
   always @(posedge clock) begin : action_check
      csi_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_actions.size() == 0) begin
            log_mismatch("unexpected result", '0, rsp_item);
         end else begin
            want = expected_actions.pop_front();
            if (rsp_item.kind !== want.kind || rsp_item.char_code !== want.char_code ||
                rsp_item.new_row !== want.new_row || rsp_item.new_col !== want.new_col ||
                rsp_item.color !== want.color || rsp_item.fg_color !== want.fg_color ||
                rsp_item.last !== want.last)
               log_mismatch("result mismatch", want, rsp_item);
         end
      end
   end

   task automatic test_plain_bytes();
      send_byte(8'h00, 8'd0, 8'd0);
      send_byte(8'hFF, 8'd255, 8'd255);
      send_byte(CHR_NL, 8'hAA, 8'h55);
   endtask

   // ESC followed by anything but '[' falls back to teletype output
   task automatic test_escape_fallback();
      send_byte(CHR_ESC, 8'd1, 8'd1);
      send_byte("q", 8'd1, 8'd1);
      send_byte(CHR_ESC, 8'd1, 8'd1);
      send_byte(CHR_ESC, 8'd1, 8'd1);
   endtask

   task automatic test_cursor_commands();
      send_csi("5A", 8'd2, 8'd9);           // row clamps at the top
      send_csi("A", 8'd200, 8'd7);          // missing count taken as one
      send_csi("70000C", 8'd3, 8'd250);     // saturated count, column wraps
      send_csi("D", 8'd255, 8'd255);        // linear row beyond a byte
      send_csi("9D", 8'd0, 8'd3);           // back past the origin clamps
      send_csi(";H", 8'd40, 8'd40);         // zero row and column
      send_csi("300;258H", 8'd0, 8'd0);     // absolute position wraps
   endtask

   task automatic test_sgr_colours();
      send_csi("38;5;200;9m", 8'd0, 8'd0);  // extra separator dropped
      send_csi("48;5;17m", 8'd0, 8'd0);
      send_csi("38;4;9m", 8'd0, 8'd0);      // not a palette select
      send_csi("m", 8'd0, 8'd0);
   endtask

   task automatic test_write_and_unknown();
      send_csi("65@", 8'd5, 8'd5);
      send_csi("7z", 8'd5, 8'd5);
      send_csi("\n", 8'd5, 8'd5);           // newline ends the sequence
   endtask

   task automatic test_random_traffic();
      int goal;
      goal = sent_bytes + RANDOM_BYTES;
      while (sent_bytes < goal) send_random_sequence();
   endtask

   // Run a stretch with neither side idling
   task automatic test_quiet_stretch();
      int goal;
      quiet_sender   <= 1'b1;
      quiet_receiver <= 1'b1;
      goal = sent_bytes + QUIET_BYTES;
      while (sent_bytes < goal) send_random_sequence();
      quiet_receiver <= 1'b0;
   endtask

   // Hold the receiver off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      int goal;
      -> hold_trigger;
      goal = sent_bytes + BURST_BYTES;
      while (sent_bytes < goal) send_random_sequence();
      quiet_sender <= 1'b0;
   endtask

   initial begin
      reset_shadow();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_plain_bytes();
      test_escape_fallback();
      test_cursor_commands();
      test_sgr_colours();
      test_write_and_unknown();
      test_random_traffic();
      test_quiet_stretch();
      test_backpressure();
      req_valid <= 1'b0;
      // wait for every expected action, then let the block settle
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_actions.size() == 0)
         $display("ansi_csi_console_parser verification clean");
      else
         $display("ansi_csi_console_parser verification failed");
      $finish;
   end

endmodule
